// ----- hw/rtl/wsfu_pkg.sv -----
// Package: shared types and constants of the short-frame unmasker
package wsfu_pkg;

	// Opcodes of interest
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	// Largest short-form length; 126 and 127 mark extended lengths
	localparam logic [6:0] SHORT_LIMIT = 7'd125;
	localparam logic [6:0] MAX_LEN_RESET = 7'd125;

	// Mask key bytes following the length byte
	localparam logic [6:0] MASK_BYTES = 7'd4;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_CLOSE   = 1'b1;

	// Parser phases, one-hot
	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_MASK    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	// One result item
	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       last_of_frame;
	} result_t;

	// Front to queue push
	typedef struct packed {
		logic    push;
		result_t item;
	} push_t;

endpackage

// ----- hw/rtl/wsfu_if.sv -----
// Interfaces: received byte channel and result channel

interface wsfu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_start;

	modport source (output valid, output data_byte, output buffer_start, input ready);
	modport sink (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface wsfu_result_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       last_of_frame;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_opcode, output last_of_frame, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_opcode, input last_of_frame, output ready);
endinterface

// ----- hw/rtl/wsfu_front.sv -----
// Front end: frame header parser, mask key capture and payload unmasking
module wsfu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             buffer_start,
	input  logic [6:0]       max_len,
	output wsfu_pkg::push_t  push
);
	import wsfu_pkg::*;

	phase_t     phase_q;
	logic [3:0] opcode_q;
	logic       masked_q;
	logic [6:0] len_q;
	logic [6:0] count_q;
	logic [7:0] key_q [4];
	logic       closed_q;

	phase_t     phase_eff;
	logic       len_bad;
	logic [7:0] count_inc;
	logic       last;
	logic       emit_data;
	logic [7:0] unmasked;

	// A buffer start restarts parsing at header byte 0
	assign phase_eff = buffer_start ? PH_HDR0 : phase_q;

	assign len_bad   = (data_byte[6:0] > max_len) || (data_byte[6:0] > SHORT_LIMIT);
	assign count_inc = {1'b0, count_q} + 8'd1;
	assign last      = count_inc >= {1'b0, len_q};
	assign emit_data = (opcode_q == OP_TEXT) || (opcode_q == OP_BINARY);
	assign unmasked  = masked_q ? (data_byte ^ key_q[count_q[1:0]]) : data_byte;

	// Result generation for the current transfer
	always_comb begin
		push = '0;
		if (accept && !closed_q) begin
			case (phase_eff)
				PH_HDR0: begin
					if (data_byte[3:0] == OP_CLOSE) begin
						push.push              = 1'b1;
						push.item.result_kind  = KIND_CLOSE;
						push.item.frame_opcode = OP_CLOSE;
					end
				end
				PH_PAYLOAD: begin
					push.push               = emit_data;
					push.item.result_kind   = KIND_PAYLOAD;
					push.item.payload_byte  = unmasked;
					push.item.frame_opcode  = opcode_q;
					push.item.last_of_frame = last;
				end
				default: begin
					push = '0;
				end
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
		end else if (accept && !closed_q) begin
			case (phase_eff)
				PH_HDR0: begin
					opcode_q <= data_byte[3:0];
					if (data_byte[3:0] == OP_CLOSE) begin
						closed_q <= 1'b1;
						phase_q  <= PH_SKIP;
					end else begin
						phase_q <= PH_HDR1;
					end
				end
				PH_HDR1: begin
					masked_q <= data_byte[7];
					len_q    <= data_byte[6:0];
					count_q  <= '0;
					if (len_bad)
						phase_q <= PH_SKIP;
					else if (data_byte[7])
						phase_q <= PH_MASK;
					else if (data_byte[6:0] == 7'd0)
						phase_q <= PH_SKIP;
					else
						phase_q <= PH_PAYLOAD;
				end
				PH_MASK: begin
					if (count_inc[6:0] >= MASK_BYTES) begin
						count_q <= '0;
						phase_q <= (len_q == 7'd0) ? PH_SKIP : PH_PAYLOAD;
					end else begin
						count_q <= count_inc[6:0];
					end
				end
				PH_PAYLOAD: begin
					count_q <= count_inc[6:0];
					if (last)
						phase_q <= PH_SKIP;
				end
				default: begin
					phase_q <= PH_SKIP;
				end
			endcase
		end
	end

	// Mask key capture
	always_ff @(posedge clk) begin
		if (accept && !closed_q && (phase_eff == PH_MASK))
			key_q[count_q[1:0]] <= data_byte;
	end

endmodule

// ----- hw/rtl/wsfu_fifo.sv -----
// Result queue between the parser and the output channel
module wsfu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsfu_pkg::push_t   push,
	output logic              space,
	output logic              rd_valid,
	input  logic              rd_ready,
	output wsfu_pkg::result_t rd_item
);
	import wsfu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign space    = count_q != FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = push.push && space;
	assign do_rd    = rd_valid && rd_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= push.item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + AW'(1);
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/websocket_short_frame_unmasker.sv -----
// Top level: short WebSocket frame receiver with payload unmasking
//
// Usage: received bytes enter on byte_in, one per transfer, with
// buffer_start marking the first header byte of a frame. The parser
// reads opcode, mask flag, 7-bit length and the mask key, and pushes one
// result per text/binary payload byte (XOR-unmasked when masked) or one close result
// into a small queue; results leave on result_out.
// Throughput: one byte per cycle while the result queue has space.
// Timing: a result is written into the result queue as the byte
// that causes it is transferred; result_out is fed from the queue.
// Stalls: byte_in.ready drops only when the result queue (DEPTH entries)
// is full; a stalled receiver holds results in the queue.
// Reset: the queue empties, the parser expects header byte 0 and the
// length limit returns to 125. After a close frame the block drops all
// bytes until reset.
// cfg_wr_en/cfg_wr_data write the length limit; write it only when idle.
module websocket_short_frame_unmasker #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data,
	wsfu_byte_if.sink         byte_in,
	wsfu_result_if.source     result_out
);
	import wsfu_pkg::*;

	logic [6:0] max_len_q;
	logic       space;
	logic       accept;
	push_t      push;
	result_t    rd_item;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_len_q <= MAX_LEN_RESET;
		else if (cfg_wr_en)
			max_len_q <= cfg_wr_data;
	end

	assign byte_in.ready = space;
	assign accept        = byte_in.valid && space;

	wsfu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (byte_in.data_byte),
		.buffer_start (byte_in.buffer_start),
		.max_len      (max_len_q),
		.push         (push)
	);

	wsfu_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space    (space),
		.rd_valid (result_out.valid),
		.rd_ready (result_out.ready),
		.rd_item  (rd_item)
	);

	assign result_out.result_kind   = rd_item.result_kind;
	assign result_out.payload_byte  = rd_item.payload_byte;
	assign result_out.frame_opcode  = rd_item.frame_opcode;
	assign result_out.last_of_frame = rd_item.last_of_frame;

endmodule
